### rtl/u8u16_pkg.sv
// shared constants and types for the utf-8 to utf-16 stream decoder
package u8u16_pkg;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned PEND_W   = 3;
    localparam int unsigned STOP_W   = 2;
    localparam int unsigned M_DATA_W = 32;

    // capacity register value after reset
    localparam logic [BYTE_W-1:0] CAP_RESET = 8'hFF;

    // lead byte class boundaries
    localparam logic [BYTE_W-1:0] LEAD_CONT = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_2B   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_3B   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4B   = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_5B   = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_6B   = 8'hFC;

    // continuation byte form and payload mask
    localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PATTERN = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_PAYLOAD = 8'h3F;

    // why decoding of a string ended
    typedef enum logic [STOP_W-1:0] {
        STOP_COMPLETE  = 2'd0,
        STOP_INVALID   = 2'd1,
        STOP_FULL      = 2'd2,
        STOP_TRUNCATED = 2'd3
    } stop_reason_t;

endpackage

### rtl/utf8_to_utf16_stream_decoder_core.sv
// utf-8 to utf-16 stream decoder, top level
// Decodes a UTF-8 string arriving one byte per request on the s_ side (s_tlast on the final
// byte) and returns a request on the m_ side for every finished character that fits and for
// the final byte. The decode is a shift and a few compares between the decoder state and the
// output register, so one byte is accepted every cycle while s_tready is high, and a result
// appears in the cycle after its byte. s_tready drops only while a held result is not taken.
// m_tuser flags a valid code unit, m_tlast marks the final byte's report. Lead bytes give
// lengths of 1 to 6; a bad lead or continuation byte, or a unit that would exceed
// cfg_wdata's byte capacity, stops decoding until the end of the string.
module utf8_to_utf16_stream_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: output capacity in bytes
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_byte
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] code_unit, [23:16] bytes_written,
                                   // [25:24] stop_reason, [31:26] zero
    output logic        m_tuser,   // unit_valid
    output logic        m_tlast    // done_res
);

    // configuration and decoder state
    logic [u8u16_pkg::BYTE_W-1:0]  cap_reg;
    logic [u8u16_pkg::UNIT_W-1:0]  acc_reg,    acc_next;
    logic [u8u16_pkg::PEND_W-1:0]  pend_reg,   pend_next;
    logic [u8u16_pkg::COUNT_W-1:0] units_reg,  units_next;
    logic                          halted_reg, halted_next;
    u8u16_pkg::stop_reason_t       cause_reg,  cause_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [u8u16_pkg::UNIT_W-1:0]  m_unit_reg;
    logic [u8u16_pkg::BYTE_W-1:0]  m_bytes_reg;
    u8u16_pkg::stop_reason_t       m_stop_reg;
    logic                          m_uvalid_reg;
    logic                          m_last_reg;

    // per-byte decode results
    logic                          accept;
    logic                          got;
    logic                          fits;
    logic [u8u16_pkg::UNIT_W-1:0]  acc_work;
    logic [u8u16_pkg::BYTE_W-1:0]  bytes_out;
    u8u16_pkg::stop_reason_t       stop_out;
    logic [u8u16_pkg::BYTE_W:0]    need_bytes;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;

    // byte count after one more unit, against the capacity
    assign need_bytes = {1'b0, units_reg, 1'b0} + 9'd2;
    assign fits       = need_bytes <= {1'b0, cap_reg};

    // decode of one byte
    always_comb begin
        acc_work    = acc_reg;
        pend_next   = pend_reg;
        units_next  = units_reg;
        halted_next = halted_reg;
        cause_next  = cause_reg;
        got         = 1'b0;
        if (!halted_reg) begin
            if (pend_reg == '0) begin
                if (s_tdata < u8u16_pkg::LEAD_CONT) begin
                    acc_work = {8'd0, s_tdata};
                    got      = 1'b1;
                end else if (s_tdata < u8u16_pkg::LEAD_2B) begin
                    halted_next = 1'b1;
                    cause_next  = u8u16_pkg::STOP_INVALID;
                end else if (s_tdata < u8u16_pkg::LEAD_3B) begin
                    acc_work  = {11'd0, s_tdata[4:0]};
                    pend_next = 3'd1;
                end else if (s_tdata < u8u16_pkg::LEAD_4B) begin
                    acc_work  = {12'd0, s_tdata[3:0]};
                    pend_next = 3'd2;
                end else if (s_tdata < u8u16_pkg::LEAD_5B) begin
                    acc_work  = {13'd0, s_tdata[2:0]};
                    pend_next = 3'd3;
                end else if (s_tdata < u8u16_pkg::LEAD_6B) begin
                    acc_work  = {14'd0, s_tdata[1:0]};
                    pend_next = 3'd4;
                end else begin
                    acc_work  = {15'd0, s_tdata[0]};
                    pend_next = 3'd5;
                end
            end else if ((s_tdata & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_PATTERN) begin
                halted_next = 1'b1;
                cause_next  = u8u16_pkg::STOP_INVALID;
            end else begin
                acc_work  = {acc_reg[9:0], s_tdata[5:0]};
                pend_next = pend_reg - 3'd1;
                got       = (pend_reg == 3'd1);
            end
            // finished character: emit unless the buffer is full
            if (got) begin
                if (fits) begin
                    units_next = units_reg + 7'd1;
                end else begin
                    got         = 1'b0;
                    halted_next = 1'b1;
                    cause_next  = u8u16_pkg::STOP_FULL;
                end
            end
        end
        acc_next = acc_work;

        bytes_out = {units_next, 1'b0};
        if (halted_next) begin
            stop_out = cause_next;
        end else if (pend_next != '0) begin
            stop_out = u8u16_pkg::STOP_TRUNCATED;
        end else begin
            stop_out = u8u16_pkg::STOP_COMPLETE;
        end

        // the final byte clears the string state
        if (s_tlast) begin
            acc_next    = '0;
            pend_next   = '0;
            units_next  = '0;
            halted_next = 1'b0;
            cause_next  = u8u16_pkg::STOP_COMPLETE;
        end
    end

    // output valid: loaded on a request that yields a result, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = got || s_tlast;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= u8u16_pkg::CAP_RESET;
            acc_reg     <= '0;
            pend_reg    <= '0;
            units_reg   <= '0;
            halted_reg  <= 1'b0;
            cause_reg   <= u8u16_pkg::STOP_COMPLETE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (accept) begin
                acc_reg    <= acc_next;
                pend_reg   <= pend_next;
                units_reg  <= units_next;
                halted_reg <= halted_next;
                cause_reg  <= cause_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_uvalid_reg <= got;
            m_unit_reg   <= got ? acc_work : '0;
            m_last_reg   <= s_tlast;
            m_bytes_reg  <= bytes_out;
            m_stop_reg   <= s_tlast ? stop_out : u8u16_pkg::STOP_COMPLETE;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_stop_reg, m_bytes_reg, m_unit_reg};
    assign m_tuser  = m_uvalid_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // a stop reason only ever rides on the final byte's report
    a_stop_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[25:24] == u8u16_pkg::STOP_COMPLETE)
        else $error("stop reason on a non-final result");

    // code unit is zero when no unit is flagged
    a_unit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[15:0] == 16'd0)
        else $error("code unit set without unit flag");

    // a halted string always records a stop cause
    a_halt_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> cause_reg != u8u16_pkg::STOP_COMPLETE)
        else $error("halted without a cause");

    // at most five continuation bytes are ever pending
    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 3'd5)
        else $error("pending count out of range");

    // a non-final result always carries a fresh unit
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser)
        else $error("result without unit or final byte");
`endif

endmodule
